// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the modules of the memory map and keyboard block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds in every cycle outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    `ASSERT_CLK(label, 1'b1 |-> (cond), msg)

`endif

// ===== hdl/mmkb_pkg.sv =====
// Package with the command codes, constants and types of the memory map block.
package mmkb_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int ROWS      = 8;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int COLS      = 5;

    localparam logic [ADDR_W-1:0] ROM_TOP     = 16'h4000;
    localparam logic [ADDR_W-1:0] MIRROR_MASK = 16'h7fff;
    localparam int                FETCH_BIT   = 6;
    localparam logic [COLS-1:0]   COL_MASK    = 5'h1f;
    localparam logic [2:0]        ROW_HIGH    = 3'b111;
    localparam logic [DATA_W-1:0] NO_DEVICE   = 8'hff;

    typedef enum logic [2:0] {
        CMD_FETCH   = 3'd0,
        CMD_READ    = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_PORT    = 3'd3,
        CMD_PRESS   = 3'd4,
        CMD_RELEASE = 3'd5,
        CMD_LOAD    = 3'd6
    } cmd_t;

    typedef struct packed {
        logic              press;
        logic              release_key;
        logic [ROW_AW-1:0] row;
        logic [COLS-1:0]   cols;
    } key_evt_t;

endpackage

// ===== hdl/mmkb_ram.sv =====
// Single-port-per-direction synchronous RAM with a registered read.
module mmkb_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mmkb_keys.sv =====
// Keyboard matrix of eight rows by five columns and its port read decoder.
`include "assert_macros.svh"

module mmkb_keys (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mmkb_pkg::key_evt_t              evt,
    input  logic [mmkb_pkg::ADDR_W-1:0]     port_addr,
    output logic [mmkb_pkg::DATA_W-1:0]     port_byte
);

    logic [mmkb_pkg::COLS-1:0] keys_reg  [mmkb_pkg::ROWS];
    logic [mmkb_pkg::COLS-1:0] keys_next [mmkb_pkg::ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mmkb_pkg::ROWS; i++)
            begin
                keys_reg[i] <= mmkb_pkg::COL_MASK;
            end
        end
        else
        begin
            keys_reg <= keys_next;
        end
    end

    always_comb
    begin
        keys_next = keys_reg;
        if (evt.press)
        begin
            keys_next[evt.row] = keys_reg[evt.row] & ~evt.cols;
        end
        else if (evt.release_key)
        begin
            keys_next[evt.row] = keys_reg[evt.row] | evt.cols;
        end
    end

    // The lowest clear bit of the high address byte selects the row.
    always_comb
    begin
        logic [7:0] hi;
        hi        = port_addr[15:8];
        port_byte = mmkb_pkg::NO_DEVICE;
        if (!port_addr[0])
        begin
            for (int r = mmkb_pkg::ROWS - 1; r >= 0; r--)
            begin
                if (!hi[r])
                begin
                    port_byte = {mmkb_pkg::ROW_HIGH, keys_reg[r]};
                end
            end
        end
    end

    `ASSERT_CLK(a_press_clears, evt.press |=>
        ((keys_reg[$past(evt.row)] & $past(evt.cols)) == '0), "key press left a column set")
    `ASSERT_CLK(a_release_sets, evt.release_key && !evt.press |=>
        ((keys_reg[$past(evt.row)] & $past(evt.cols)) == $past(evt.cols)),
        "key release left a column clear")
    `ASSERT_ALWAYS(a_odd_port, !port_addr[0] || (port_byte == mmkb_pkg::NO_DEVICE),
        "odd port address returned a keyboard row")

endmodule

// ===== hdl/memory_map_and_keyboard_matrix.sv =====
// Top level of the bus-side memory map and keyboard matrix block.
// Each input transaction carries one bus command (cmd, address, write_data,
// key_row, key_columns) on a valid/ready channel; every command yields
// exactly one output transaction carrying read_data on a second valid/ready
// channel. Fetches and reads return a byte of the 64K memory, port reads a
// keyboard row or 8'hff when no row is selected, and all other commands return zero.
// The memory read and the read stage register fill at the accepting edge and
// the output register fills when the read stage advances, raising out_valid;
// the result transaction completes at an edge with out_ready high. The block
// accepts one transaction per cycle; the single memory, written and read at
// the acceptance edge, fixes that rate, and the one item held between the
// memory read and the output register keeps it while out_ready is high.
// Reset clears the valid flags of both pipeline stages and sets every keyboard row to all ones;
// memory content is undefined until written. When the receiver holds
// out_ready low, the output register keeps its transaction, one more item
// may enter the read stage, and in_ready then falls until the output moves.
`include "assert_macros.svh"

module memory_map_and_keyboard_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    cmd,
    input  logic [mmkb_pkg::ADDR_W-1:0]   address,
    input  logic [mmkb_pkg::DATA_W-1:0]   write_data,
    input  logic [mmkb_pkg::ROW_AW-1:0]   key_row,
    input  logic [mmkb_pkg::COLS-1:0]     key_columns,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mmkb_pkg::DATA_W-1:0]   read_data
);

    logic                          accept;
    logic                          s1_adv;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    // Read stage payload: where the result comes from.
    logic                          s1_sel_mem_reg;
    logic                          s1_gate_reg;
    logic [mmkb_pkg::DATA_W-1:0]   s1_imm_reg;
    logic [mmkb_pkg::DATA_W-1:0]   read_data_reg;
    logic [mmkb_pkg::DATA_W-1:0]   read_data_next;

    logic                          sel_mem;
    logic                          gate;
    logic [mmkb_pkg::DATA_W-1:0]   imm;
    logic                          ram_we;
    logic                          ram_re;
    logic [mmkb_pkg::ADDR_W-1:0]   mem_addr;
    logic [mmkb_pkg::ADDR_W:0]     addr_wide;
    logic [mmkb_pkg::ADDR_W:0]     addr_wrap;
    logic [mmkb_pkg::MEM_AW-1:0]   mem_idx;
    logic [mmkb_pkg::DATA_W-1:0]   ram_rdata;
    logic [mmkb_pkg::DATA_W-1:0]   port_byte;
    mmkb_pkg::key_evt_t            evt;

    assign accept   = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Command decode at the acceptance edge.
    always_comb
    begin
        sel_mem         = 1'b0;
        gate            = 1'b0;
        imm             = '0;
        ram_we          = 1'b0;
        mem_addr        = address;
        evt.press       = 1'b0;
        evt.release_key = 1'b0;
        evt.row         = key_row;
        evt.cols        = key_columns;
        case (mmkb_pkg::cmd_t'(cmd))
            mmkb_pkg::CMD_FETCH:
            begin
                // Fetches above the mirror boundary see the lower half.
                sel_mem  = 1'b1;
                gate     = address[mmkb_pkg::ADDR_W-1];
                mem_addr = address & mmkb_pkg::MIRROR_MASK;
            end
            mmkb_pkg::CMD_READ:
            begin
                sel_mem = 1'b1;
            end
            mmkb_pkg::CMD_WRITE:
            begin
                // The low region is read-only to guarded writes.
                ram_we = accept && (address >= mmkb_pkg::ROM_TOP);
            end
            mmkb_pkg::CMD_PORT:
            begin
                imm = port_byte;
            end
            mmkb_pkg::CMD_PRESS:
            begin
                evt.press = accept;
            end
            mmkb_pkg::CMD_RELEASE:
            begin
                evt.release_key = accept;
            end
            mmkb_pkg::CMD_LOAD:
            begin
                ram_we = accept;
            end
            default:
            begin
                sel_mem = 1'b0;
            end
        endcase
    end

    assign ram_re = accept && sel_mem;

    // Addresses wrap at the memory depth; with a 16-bit address and a depth of 65536 the subtraction never fires.
    assign addr_wide = {1'b0, mem_addr};
    assign addr_wrap = (addr_wide >= (mmkb_pkg::ADDR_W + 1)'(mmkb_pkg::MEM_DEPTH))
                     ? addr_wide - (mmkb_pkg::ADDR_W + 1)'(mmkb_pkg::MEM_DEPTH)
                     : addr_wide;
    assign mem_idx   = addr_wrap[mmkb_pkg::MEM_AW-1:0];

    mmkb_ram #(
        .DEPTH (mmkb_pkg::MEM_DEPTH),
        .WIDTH (mmkb_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (mem_idx),
        .wdata (write_data),
        .re    (ram_re),
        .raddr (mem_idx),
        .rdata (ram_rdata)
    );

    mmkb_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .port_addr (address),
        .port_byte (port_byte)
    );

    // A mirrored fetch only passes bytes with the fetch bit set.
    always_comb
    begin
        if (!s1_sel_mem_reg)
        begin
            read_data_next = s1_imm_reg;
        end
        else if (s1_gate_reg && !ram_rdata[mmkb_pkg::FETCH_BIT])
        begin
            read_data_next = '0;
        end
        else
        begin
            read_data_next = ram_rdata;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sel_mem_reg <= sel_mem;
            s1_gate_reg    <= gate;
            s1_imm_reg     <= imm;
        end
        if (s1_adv)
        begin
            read_data_reg <= read_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    `ASSERT_CLK(a_accept_fills, accept |=> s1_valid_reg, "accepted item lost before read stage")
    `ASSERT_ALWAYS(a_ready_stall, in_ready || (s1_valid_reg && out_valid_reg && !out_ready),
        "input stalled while a stage was free")
    `ASSERT_ALWAYS(a_guard, !ram_we || (mmkb_pkg::cmd_t'(cmd) == mmkb_pkg::CMD_LOAD)
        || (address >= mmkb_pkg::ROM_TOP), "guarded write reached the low region")
    `ASSERT_CLK(a_adv_output, s1_adv |=> out_valid_reg, "read stage moved without a result")

endmodule
